>>> sv/vaed_pkg.sv
// Package for the ADC event decoder: sizes, word codes, result types and helpers.
// Depends on nothing; every other file of the block imports it.
package vaed_pkg;

	localparam int MODULES         = 2;
	localparam int CHANNELS        = 32;
	localparam int STRIPS_PER_SIDE = 16;

	localparam int MOD_IDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;
	localparam int WORD_W    = 16;
	localparam int CH_W      = 5;
	localparam int CNT_W     = 6;
	localparam int DLEN_W    = 10;

	localparam logic [WORD_W-1:0]   THR_RESET = 16'd100;
	localparam logic [CHANNELS-1:0] X_MASK    =
		CHANNELS'((64'd1 << STRIPS_PER_SIDE) - 64'd1);

	// top two bits of the high half of a 32-bit word
	localparam logic [1:0] TYPE_DATA = 2'b00;
	localparam logic [1:0] TYPE_HDR  = 2'b01;
	localparam logic [1:0] TYPE_EOE  = 2'b11;
	// bits 15:5 of a data event high half
	localparam logic [10:0] DATA_TAG = 11'h020;
	localparam logic [WORD_W-1:0] SEG_ID_ADC = 16'd1;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_MULT = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_BAD_HDR   = 2'd1;
	localparam logic [1:0] ERR_NOT_EVENT = 2'd2;
	localparam logic [1:0] ERR_UNKNOWN   = 2'd3;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_ID,
		PH_HDR_LO,
		PH_HDR_HI,
		PH_DAT_LO,
		PH_DAT_HI,
		PH_SKIP_LO,
		PH_SKIP_HI
	} phase_t;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              module_bit;
		logic [CH_W-1:0]   raw_channel;
		logic [CH_W-1:0]   strip_channel;
		logic [WORD_W-1:0] adc_value;
		cnt_t              x_hits;
		cnt_t              y_hits;
		logic [1:0]        error_code;
		logic              end_mark;
	} result_t;

	// decoder to emitter: what one item produced
	typedef struct packed {
		logic                     rec_v;
		result_t                  rec;
		logic                     mult_v;
		cnt_t [MODULES-1:0]       x_hits;
		cnt_t [MODULES-1:0]       y_hits;
	} dec_out_t;

	// 16-23 and 24-31 are mirrored within their group
	function automatic logic [CH_W-1:0] strip_of(input logic [CH_W-1:0] ch);
		logic [5:0] wide;
		wide = {1'b0, ch};
		if (ch >= 5'd24)
			return CH_W'(6'd55 - wide);
		else if (ch >= 5'd16)
			return CH_W'(6'd39 - wide);
		else
			return ch;
	endfunction

	function automatic cnt_t count_ones(input logic [CHANNELS-1:0] v);
		cnt_t n;
		n = '0;
		for (int i = 0; i < CHANNELS; i++)
			n = n + cnt_t'(v[i]);
		return n;
	endfunction

endpackage

>>> sv/vaed_if.sv
// Channel interfaces of the ADC event decoder: word input, result output, config.
// Depends on vaed_pkg.
interface vaed_in_if import vaed_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] raw_word;
	logic              last_word;

	modport source (output valid, raw_word, last_word, input ready);
	modport sink   (input valid, raw_word, last_word, output ready);
endinterface

interface vaed_out_if import vaed_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic              module_bit;
	logic [CH_W-1:0]   raw_channel;
	logic [CH_W-1:0]   strip_channel;
	logic [WORD_W-1:0] adc_value;
	logic [CNT_W-1:0]  x_hits;
	logic [CNT_W-1:0]  y_hits;
	logic [1:0]        error_code;
	logic              end_mark;

	modport source (output valid, kind, module_bit, raw_channel, strip_channel, adc_value,
		x_hits, y_hits, error_code, end_mark, input ready);
	modport sink   (input valid, kind, module_bit, raw_channel, strip_channel, adc_value,
		x_hits, y_hits, error_code, end_mark, output ready);
endinterface

interface vaed_cfg_if import vaed_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] hit_threshold;

	modport source (output valid, hit_threshold, input ready);
	modport sink   (input valid, hit_threshold, output ready);
endinterface

>>> sv/vaed_decoder.sv
// Segment parser and hit store: decodes one registered word per advance.
// Depends on vaed_pkg.
module vaed_decoder import vaed_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [WORD_W-1:0] word,
	input  logic              last,
	input  logic [WORD_W-1:0] thr,
	output dec_out_t          dout
);

	phase_t                           phase_q, phase_n;
	logic [WORD_W-1:0]                seg_left_q, seg_n;
	logic                             seg_adc_q, adc_n;
	logic [WORD_W-1:0]                low_half_q, low_n;
	logic [DLEN_W-1:0]                data_left_q, data_n;
	logic                             cur_mod_q, cur_n;
	logic [MODULES-1:0][CHANNELS-1:0] hits_q, hits_n, hits_upd;

	logic [WORD_W-1:0] seg_dec;
	logic [DLEN_W-1:0] data_dec;
	logic [1:0]        wtype;
	logic [CH_W-1:0]   ch, st;
	logic              hdr_ok, dat_ok;
	logic [MOD_IDX_W-1:0] mi;
	phase_t            done_ph;

	assign seg_dec  = (phase_q != PH_SIZE && seg_left_q != '0) ? seg_left_q - 16'd1
		: seg_left_q;
	assign data_dec = data_left_q - 10'd1;
	assign wtype    = word[15:14];
	assign ch       = word[CH_W-1:0];
	assign st       = strip_of(ch);
	assign hdr_ok   = (wtype == TYPE_HDR);
	assign dat_ok   = (word[15:5] == DATA_TAG);
	assign mi       = (MODULES == 1) ? '0 : MOD_IDX_W'(cur_mod_q);
	// where a finished pair or block goes next
	assign done_ph  = (seg_dec == '0) ? PH_SIZE : (seg_adc_q ? PH_HDR_LO : PH_SKIP_LO);

	// next state
	always_comb begin
		phase_n = phase_q;
		seg_n   = seg_dec;
		adc_n   = seg_adc_q;
		low_n   = low_half_q;
		data_n  = data_left_q;
		cur_n   = cur_mod_q;
		unique case (phase_q)
			PH_SIZE: begin
				seg_n   = (word != '0) ? word - 16'd1 : '0;
				phase_n = PH_ID;
			end
			PH_ID: begin
				adc_n   = (word == SEG_ID_ADC);
				phase_n = (seg_dec == '0) ? PH_SIZE
					: ((word == SEG_ID_ADC) ? PH_HDR_LO : PH_SKIP_LO);
			end
			PH_HDR_LO: begin
				low_n   = word;
				phase_n = PH_HDR_HI;
			end
			PH_DAT_LO: begin
				low_n   = word;
				phase_n = PH_DAT_HI;
			end
			PH_SKIP_LO: begin
				low_n   = word;
				phase_n = PH_SKIP_HI;
			end
			PH_HDR_HI: begin
				if (hdr_ok) begin
					cur_n   = word[0];
					data_n  = low_half_q[DLEN_W-1:0];
					phase_n = (low_half_q[DLEN_W-1:0] == '0) ? done_ph : PH_DAT_LO;
				end else begin
					phase_n = done_ph;
				end
			end
			PH_DAT_HI: begin
				data_n  = data_dec;
				phase_n = (data_dec == '0) ? done_ph : PH_DAT_LO;
			end
			PH_SKIP_HI: begin
				phase_n = done_ph;
			end
		endcase
		hits_n = hits_upd;
		if (last) begin
			phase_n = PH_SIZE;
			seg_n   = '0;
			adc_n   = 1'b0;
			low_n   = '0;
			data_n  = '0;
			cur_n   = 1'b0;
			hits_n  = '0;
		end
	end

	// outputs and hit store update
	always_comb begin
		dout     = '0;
		hits_upd = hits_q;
		if (phase_q == PH_HDR_HI && !hdr_ok) begin
			dout.rec_v          = 1'b1;
			dout.rec.kind       = KIND_ERR;
			dout.rec.error_code = ERR_BAD_HDR;
		end
		if (phase_q == PH_DAT_HI) begin
			unique case (wtype)
				TYPE_DATA: begin
					dout.rec_v = 1'b1;
					if (dat_ok) begin
						dout.rec.kind          = KIND_DATA;
						dout.rec.module_bit    = cur_mod_q;
						dout.rec.raw_channel   = ch;
						dout.rec.strip_channel = st;
						dout.rec.adc_value     = low_half_q;
						hits_upd[mi][st]       = (low_half_q > thr);
					end else begin
						dout.rec.kind       = KIND_ERR;
						dout.rec.error_code = ERR_NOT_EVENT;
					end
				end
				TYPE_EOE: begin
				end
				default: begin
					dout.rec_v          = 1'b1;
					dout.rec.kind       = KIND_ERR;
					dout.rec.error_code = ERR_UNKNOWN;
				end
			endcase
		end
		dout.mult_v = last;
		for (int m = 0; m < MODULES; m++) begin
			dout.x_hits[m] = count_ones(hits_upd[m] & X_MASK);
			dout.y_hits[m] = count_ones(hits_upd[m] & ~X_MASK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			seg_left_q  <= '0;
			seg_adc_q   <= 1'b0;
			low_half_q  <= '0;
			data_left_q <= '0;
			cur_mod_q   <= 1'b0;
			hits_q      <= '0;
		end else if (adv) begin
			phase_q     <= phase_n;
			seg_left_q  <= seg_n;
			seg_adc_q   <= adc_n;
			low_half_q  <= low_n;
			data_left_q <= data_n;
			cur_mod_q   <= cur_n;
			hits_q      <= hits_n;
		end
	end

endmodule

>>> sv/vaed_emitter.sv
// Result register: holds one item's results; hands one out per out_ready cycle.
// Depends on vaed_pkg.
module vaed_emitter import vaed_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  dec_out_t din,
	input  logic     out_ready,
	output logic     out_valid,
	output result_t  out_res,
	output logic     free
);

	logic                 rec_v_q, mult_v_q;
	result_t              rec_q;
	logic [MOD_IDX_W-1:0] idx_q;
	cnt_t [MODULES-1:0]   xh_q, yh_q;

	logic idx_last, last_beat, take;

	assign idx_last  = (idx_q == MOD_IDX_W'(MODULES - 1));
	assign out_valid = rec_v_q | mult_v_q;
	assign last_beat = rec_v_q ? !mult_v_q : (mult_v_q && idx_last);
	assign take      = out_valid && out_ready;
	assign free      = !out_valid || (take && last_beat);

	always_comb begin
		if (rec_v_q) begin
			out_res          = rec_q;
			out_res.end_mark = !mult_v_q;
		end else begin
			out_res            = '0;
			out_res.kind       = KIND_MULT;
			out_res.module_bit = idx_q[0];
			out_res.x_hits     = xh_q[idx_q];
			out_res.y_hits     = yh_q[idx_q];
			out_res.end_mark   = idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_v_q  <= 1'b0;
			mult_v_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			rec_v_q  <= din.rec_v;
			mult_v_q <= din.mult_v;
			idx_q    <= '0;
		end else if (take) begin
			if (rec_v_q)
				rec_v_q <= 1'b0;
			else if (idx_last)
				mult_v_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= din.rec;
			xh_q  <= din.x_hits;
			yh_q  <= din.y_hits;
		end
	end

endmodule

>>> sv/vme_adc_event_decoder.sv
// Top level of the multichannel ADC event decoder: input register, threshold
// register, parser and result register. Depends on vaed_pkg, vaed_if, vaed_decoder, vaed_emitter.
//
//  channel    | dir | payload                                    | handshake
//  -----------+-----+--------------------------------------------+-----------
//  word_ch    | in  | raw_word[15:0], last_word                  | valid/ready
//  result_ch  | out | kind, module_bit, raw/strip channel, value,| valid/ready
//             |     | x_hits, y_hits, error_code, end_mark       |
//  cfg_ch     | in  | hit_threshold[15:0]                        | valid/ready
//
// One word is taken per cycle while word_ch.ready is high. A word is held in the input
// register, is decoded there and moves into the result register once that is free.
// Words giving at most one result run back to back; the last word of an event
// gives up to 1 + MODULES results, and the result register holds the input
// stage until every extra result is taken. A stall on result_ch backs up
// into the input register and then drops word_ch.ready.
// Reset (arst_n low) clears parse state, hit store and threshold (to 100).
module vme_adc_event_decoder import vaed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	vaed_in_if.sink     word_ch,
	vaed_out_if.source  result_ch,
	vaed_cfg_if.sink    cfg_ch
);

	// input register
	logic              s1_v_q;
	logic [WORD_W-1:0] word_s1;
	logic              last_s1;

	logic [WORD_W-1:0] thr_q;

	dec_out_t dec_out;
	result_t  res;
	logic     emit_free, adv, res_valid;

	// the registered word moves on once the result register can take all it yields
	assign adv           = s1_v_q && emit_free;
	assign word_ch.ready = !s1_v_q || adv;

	// config is to be written only while idle; the block does not enforce it; always accept
	assign cfg_ch.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			thr_q  <= THR_RESET;
		end else begin
			if (word_ch.valid && word_ch.ready)
				s1_v_q <= 1'b1;
			else if (adv)
				s1_v_q <= 1'b0;
			if (cfg_ch.valid)
				thr_q <= cfg_ch.hit_threshold;
		end
	end

	always_ff @(posedge clk) begin
		if (word_ch.valid && word_ch.ready) begin
			word_s1 <= word_ch.raw_word;
			last_s1 <= word_ch.last_word;
		end
	end

	vaed_decoder u_decoder (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.word   (word_s1),
		.last   (last_s1),
		.thr    (thr_q),
		.dout   (dec_out)
	);

	vaed_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.din       (dec_out),
		.out_ready (result_ch.ready),
		.out_valid (res_valid),
		.out_res   (res),
		.free      (emit_free)
	);

	assign result_ch.valid         = res_valid;
	assign result_ch.kind          = res.kind;
	assign result_ch.module_bit    = res.module_bit;
	assign result_ch.raw_channel   = res.raw_channel;
	assign result_ch.strip_channel = res.strip_channel;
	assign result_ch.adc_value     = res.adc_value;
	assign result_ch.x_hits        = res.x_hits;
	assign result_ch.y_hits        = res.y_hits;
	assign result_ch.error_code    = res.error_code;
	assign result_ch.end_mark      = res.end_mark;

`ifndef SYNTHESIS
	// an item's results come out without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.ready && !result_ch.end_mark |=> result_ch.valid)
		else $error("result gap inside one item");

	// last word of an event always leads to multiplicity results
	a_mult_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && dec_out.mult_v |=> result_ch.valid)
		else $error("multiplicity results not presented");

	// the last module's multiplicity closes the item
	a_mult_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.kind == KIND_MULT
		&& result_ch.module_bit == 1'(MODULES - 1) |-> result_ch.end_mark)
		else $error("final multiplicity without end mark");
`endif

endmodule

>>> tb/tb.sv
// Testbench for vme_adc_event_decoder: a queue-fed word driver, a result monitor and a
// word-level decoder model that keeps the expected results in order.
// Depends on vaed_pkg, vaed_if and the decoder RTL.
`timescale 1ns / 100ps

module tb import vaed_pkg::*; ();

	localparam int          RUN_LIMIT = 200000;
	localparam logic [31:0] X_SIDE    = (32'h1 << STRIPS_PER_SIDE) - 32'h1;

	typedef struct packed {
		logic        last;
		logic [15:0] w;
	} word_item_t;

	logic clk = 1'b0;
	logic arst_n;

	vaed_in_if  word_ch();
	vaed_out_if result_ch();
	vaed_cfg_if cfg_ch();

	vme_adc_event_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_ch   (word_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	word_item_t  pending_words[$];
	result_t     expected_results[$];
	logic [15:0] event_words[$];
	logic [15:0] seg_body[$];
	int          words_queued;
	int          words_sent;
	int          results_seen;
	int          fails;
	int          hold_left;
	int unsigned cycles;

	// decoder model state
	logic [15:0] threshold_now;
	phase_t      parse_at;
	logic [15:0] seg_left;
	logic        seg_adc;
	logic [15:0] lo_half;
	logic [9:0]  dat_left;
	logic        cur_mod;
	logic [31:0] hit_store[MODULES];

	function automatic void model_reset();
		threshold_now = THR_RESET;
		parse_at      = PH_SIZE;
		seg_left      = '0;
		seg_adc       = 1'b0;
		lo_half       = '0;
		dat_left      = '0;
		cur_mod       = 1'b0;
		for (int m = 0; m < MODULES; m++)
			hit_store[m] = '0;
	endfunction

	function automatic logic [4:0] mirrored_strip(input logic [4:0] ch);
		if (ch >= 5'd24)
			return 5'(55 - int'(ch));
		if (ch >= 5'd16)
			return 5'(39 - int'(ch));
		return ch;
	endfunction

	function automatic result_t mk_result(input logic [1:0] kind, input logic mod,
		input logic [4:0] rch, input logic [4:0] sch, input logic [15:0] val,
		input logic [5:0] xh, input logic [5:0] yh, input logic [1:0] err);
		result_t r;
		r.kind          = kind;
		r.module_bit    = mod;
		r.raw_channel   = rch;
		r.strip_channel = sch;
		r.adc_value     = val;
		r.x_hits        = xh;
		r.y_hits        = yh;
		r.error_code    = err;
		r.end_mark      = 1'b0;
		return r;
	endfunction

	// next block after a header/data unit or a skipped pair
	function automatic void unit_finished();
		if (seg_left == 0)
			parse_at = PH_SIZE;
		else
			parse_at = seg_adc ? PH_HDR_LO : PH_SKIP_LO;
	endfunction

	function automatic void decode_expected(input logic [15:0] w, input logic last);
		result_t     outs[$];
		phase_t      p;
		logic [4:0]  ch;
		logic [4:0]  st;
		logic [31:0] h;
		int          mi;
		p = parse_at;
		if (p != PH_SIZE && seg_left != 0)
			seg_left = seg_left - 16'd1;
		case (p)
			PH_SIZE: begin
				seg_left = (w != 0) ? w - 16'd1 : 16'd0;
				parse_at = PH_ID;
			end
			PH_ID: begin
				seg_adc = (w == SEG_ID_ADC);
				unit_finished();
			end
			PH_HDR_LO, PH_DAT_LO, PH_SKIP_LO: begin
				lo_half  = w;
				parse_at = phase_t'(p + 3'd1);
			end
			PH_HDR_HI: begin
				if (w[15:14] == TYPE_HDR) begin
					cur_mod  = w[0];
					dat_left = lo_half[9:0];
					if (dat_left == 0)
						unit_finished();
					else
						parse_at = PH_DAT_LO;
				end else begin
					outs.push_back(mk_result(KIND_ERR, 0, 0, 0, 0, 0, 0, ERR_BAD_HDR));
					unit_finished();
				end
			end
			PH_DAT_HI: begin
				if (w[15:14] == TYPE_DATA) begin
					if (w[15:5] == DATA_TAG) begin
						ch = w[4:0];
						st = mirrored_strip(ch);
						mi = int'(cur_mod) % MODULES;
						// a repeated channel simply overwrites its bit
						hit_store[mi][st] = (lo_half > threshold_now);
						outs.push_back(mk_result(KIND_DATA, cur_mod, ch, st, lo_half,
							0, 0, ERR_NONE));
					end else begin
						outs.push_back(mk_result(KIND_ERR, 0, 0, 0, 0, 0, 0, ERR_NOT_EVENT));
					end
				end else if (w[15:14] != TYPE_EOE) begin
					outs.push_back(mk_result(KIND_ERR, 0, 0, 0, 0, 0, 0, ERR_UNKNOWN));
				end
				dat_left = dat_left - 10'd1;
				if (dat_left == 0)
					unit_finished();
				else
					parse_at = PH_DAT_LO;
			end
			default: unit_finished();
		endcase
		if (last) begin
			for (int m = 0; m < MODULES; m++) begin
				h = hit_store[m];
				outs.push_back(mk_result(KIND_MULT, 1'(m), 0, 0, 0,
					6'($countones(h & X_SIDE)), 6'($countones(h & ~X_SIDE)), ERR_NONE));
				hit_store[m] = '0;
			end
			parse_at = PH_SIZE;
			seg_left = '0;
			seg_adc  = 1'b0;
			lo_half  = '0;
			dat_left = '0;
			cur_mod  = 1'b0;
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].end_mark = 1'b1;
		foreach (outs[i])
			expected_results.push_back(outs[i]);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	function automatic void check_result(input result_t want, input result_t got);
		check_field("kind", want.kind, got.kind);
		check_field("module_bit", want.module_bit, got.module_bit);
		check_field("raw_channel", want.raw_channel, got.raw_channel);
		check_field("strip_channel", want.strip_channel, got.strip_channel);
		check_field("adc_value", want.adc_value, got.adc_value);
		check_field("x_hits", want.x_hits, got.x_hits);
		check_field("y_hits", want.y_hits, got.y_hits);
		check_field("error_code", want.error_code, got.error_code);
		check_field("end_mark", want.end_mark, got.end_mark);
	endfunction

	// word driver: model is stepped on each accepted item
	always @(posedge clk) begin
		word_item_t nxt;
		logic       quiet;
		if (!arst_n) begin
			word_ch.valid <= 1'b0;
		end else begin
			if (word_ch.valid && word_ch.ready) begin
				decode_expected(word_ch.raw_word, word_ch.last_word);
				words_sent++;
			end
			if (!word_ch.valid || word_ch.ready) begin
				quiet = (words_sent >= 250 && words_sent < 330);
				if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
					nxt = pending_words.pop_front();
					word_ch.valid     <= 1'b1;
					word_ch.raw_word  <= nxt.w;
					word_ch.last_word <= nxt.last;
				end else begin
					word_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with its own long hold-offs
	always @(posedge clk) begin
		result_t got;
		logic    quiet;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got.kind          = result_ch.kind;
				got.module_bit    = result_ch.module_bit;
				got.raw_channel   = result_ch.raw_channel;
				got.strip_channel = result_ch.strip_channel;
				got.adc_value     = result_ch.adc_value;
				got.x_hits        = result_ch.x_hits;
				got.y_hits        = result_ch.y_hits;
				got.error_code    = result_ch.error_code;
				got.end_mark      = result_ch.end_mark;
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual kind %0d",
						$time, got.kind);
					fails++;
				end else begin
					check_result(expected_results.pop_front(), got);
				end
				if (results_seen == 60 || results_seen == 180)
					hold_left = 150;
			end
			quiet = (results_seen >= 110 && results_seen < 170);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= quiet || ($urandom_range(99) >= 9);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_word(input logic [15:0] w, input logic last);
		word_item_t it;
		it.w    = w;
		it.last = last;
		pending_words.push_back(it);
		words_queued++;
	endtask

	// sender waits for every result, then lets the pipe empty
	task automatic wait_drain();
		while (pending_words.size() != 0 || word_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] v);
		@(posedge clk);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.hit_threshold <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid  <= 1'b0;
		threshold_now = v;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return threshold_now;
			2: return threshold_now + 16'd1;
			default: return threshold_now - 16'd1;
		endcase
	endfunction

	// segment size counts the size and id words; now and then it is made wrong
	task automatic close_segment(input logic [15:0] id);
		int sz;
		sz = seg_body.size() + 2;
		if ($urandom_range(9) == 0)
			sz = sz + int'($urandom_range(4)) - 2;
		event_words.push_back(16'(sz));
		event_words.push_back(id);
		foreach (seg_body[i])
			event_words.push_back(seg_body[i]);
	endtask

	task automatic add_adc_segment();
		int n;
		int r;
		seg_body.delete();
		repeat ($urandom_range(1, 2)) begin
			n = $urandom_range(0, 5);
			seg_body.push_back({6'($urandom), 10'(n)});
			if ($urandom_range(19) == 0)
				seg_body.push_back(16'($urandom));
			else
				seg_body.push_back({TYPE_HDR, 13'($urandom), 1'($urandom)});
			repeat (n) begin
				r = $urandom_range(99);
				seg_body.push_back(pick_value());
				if (r < 84)
					seg_body.push_back({DATA_TAG, 5'($urandom)});
				else if (r < 90)
					seg_body.push_back({TYPE_EOE, 14'($urandom)});
				else if (r < 95)
					seg_body.push_back({TYPE_DATA, 14'($urandom)});
				else
					seg_body.push_back({2'($urandom_range(1, 2)), 14'($urandom)});
			end
		end
		close_segment(SEG_ID_ADC);
	endtask

	task automatic add_skip_segment();
		logic [15:0] id;
		seg_body.delete();
		id = 16'($urandom);
		if (id == SEG_ID_ADC)
			id = 16'd2;
		repeat (2 * $urandom_range(0, 3))
			seg_body.push_back(16'($urandom));
		close_segment(id);
	endtask

	task automatic queue_event();
		int r;
		event_words.delete();
		repeat ($urandom_range(1, 3)) begin
			r = $urandom_range(99);
			if (r < 70)
				add_adc_segment();
			else if (r < 88)
				add_skip_segment();
			else
				repeat ($urandom_range(1, 6))
					event_words.push_back(16'($urandom));
		end
		// a truncated event ends part way through a block
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(0, event_words.size() - 1))
				void'(event_words.pop_back());
		foreach (event_words[i])
			push_word(event_words[i], i == event_words.size() - 1);
	endtask

	task automatic run_random(input int words);
		int target;
		target = words_queued + words;
		while (words_queued < target) begin
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 8))
					push_word(16'($urandom), $urandom_range(9) == 0);
			else
				queue_event();
		end
	endtask

	// short segment, skipped segment, repeated channel, end-of-event word,
	// the not-event and unknown-type error codes, value equal to the threshold, and the last word
	localparam logic [16:0] DIRECTED [28] = '{
		17'h0_0000, 17'h0_FFFF, 17'h0_0004, 17'h0_0007, 17'h0_1234, 17'h0_ABCD,
		17'h0_0014, 17'h0_0001, 17'h0_0005, 17'h0_4001, 17'h0_0032, 17'h0_0410,
		17'h0_FFFF, 17'h0_0410, 17'h0_0065, 17'h0_0405, 17'h0_0000, 17'h0_C000,
		17'h0_0200, 17'h0_001F, 17'h0_0001, 17'h0_8000, 17'h0_0002, 17'h0_4000,
		17'h0_00C8, 17'h0_8000, 17'h0_0064, 17'h1_041F
	};

	initial begin
		arst_n               = 1'b0;
		word_ch.valid        = 1'b0;
		word_ch.raw_word     = '0;
		word_ch.last_word    = 1'b0;
		result_ch.ready      = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.hit_threshold = '0;
		words_queued         = 0;
		words_sent           = 0;
		results_seen         = 0;
		fails                = 0;
		hold_left            = 0;
		cycles               = 0;
		model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			push_word(DIRECTED[i][15:0], DIRECTED[i][16]);
		wait_drain();

		write_threshold(16'd0);
		run_random(100);
		wait_drain();
		write_threshold(16'hFFFF);
		run_random(90);
		wait_drain();
		write_threshold(16'($urandom));
		run_random(120);
		wait_drain();
		write_threshold(THR_RESET);
		run_random(100);
		wait_drain();

		$display("%0d words decoded into %0d checked results under five thresholds,",
			words_sent, results_seen);
		$display("with skipped, short, broken and truncated segments and long stalls.");
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
